@@ rtl/core/wsd_pkg.sv @@
package wsd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 64;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned OpcodeW  = 4;
  localparam int unsigned CountW   = 4;
  localparam int unsigned OutDataW = 112;

  localparam logic [6:0]        LenCode16  = 7'd126;
  localparam logic [6:0]        LenCode64  = 7'd127;
  localparam logic [CountW-1:0] Ext16Bytes = 4'd2;
  localparam logic [CountW-1:0] Ext64Bytes = 4'd8;
  localparam logic [CountW-1:0] KeyBytes   = 4'd4;

  typedef enum logic [1:0] {
    KIND_HEADER     = 2'd0,
    KIND_DATA       = 2'd1,
    KIND_INCOMPLETE = 2'd2
  } wsd_kind_e;

  typedef enum logic [5:0] {
    PH_FIRST  = 6'b000001,
    PH_SECOND = 6'b000010,
    PH_EXT16  = 6'b000100,
    PH_EXT64  = 6'b001000,
    PH_KEY    = 6'b010000,
    PH_DATA   = 6'b100000
  } wsd_phase_e;

  // one input item as held in the input register
  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_data;
  } wsd_in_t;

  // one result item
  typedef struct packed {
    wsd_kind_e          kind;
    logic               fin;
    logic [OpcodeW-1:0] opcode;
    logic               masked;
    logic [LenW-1:0]    payload_length;
    logic [KeyW-1:0]    masking_key;
    logic [ByteW-1:0]   data_byte;
    logic               last_of_frame;
    logic               incomplete;
  } wsd_result_t;

endpackage

@@ rtl/core/wsd_in_stage.sv @@
module wsd_in_stage
  import wsd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  wsd_in_t item_i,
  output logic    valid_o,
  input  logic    take_i,
  output wsd_in_t item_o
);

  logic    valid_q, valid_d;
  wsd_in_t item_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/core/wsd_parser.sv @@
module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  wsd_in_t     in_item_i,
  output logic        take_o,
  input  logic        out_free_i,
  output logic        res_valid_o,
  output wsd_result_t res_o
);

  wsd_phase_e         phase_q, phase_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [LenW-1:0]    rem_q, rem_d;
  logic               fin_q, fin_d;
  logic [OpcodeW-1:0] op_q, op_d;
  logic               masked_q, masked_d;

  logic             hit;
  wsd_kind_e        kind;
  logic [ByteW-1:0] data_byte;
  logic             last;
  logic             inc;
  logic             hdr_done;
  logic [ByteW-1:0] b;
  logic             eod;
  logic [CountW-1:0] cnt_inc;
  logic             len_done;

  assign b       = in_item_i.in_byte;
  assign eod     = in_item_i.end_of_data;
  assign cnt_inc = cnt_q + 4'd1;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    key_d     = key_q;
    rem_d     = rem_q;
    fin_d     = fin_q;
    op_d      = op_q;
    masked_d  = masked_q;
    hit       = 1'b0;
    kind      = KIND_INCOMPLETE;
    data_byte = '0;
    last      = 1'b0;
    inc       = 1'b0;
    hdr_done  = 1'b0;
    len_done  = 1'b0;

    unique case (phase_q)
      PH_FIRST: begin
        fin_d    = b[7];
        op_d     = b[OpcodeW-1:0];
        masked_d = 1'b0;
        len_d    = '0;
        key_d    = '0;
        rem_d    = '0;
        cnt_d    = '0;
        phase_d  = PH_SECOND;
      end
      PH_SECOND: begin
        masked_d = b[7];
        cnt_d    = '0;
        if (b[6:0] == LenCode16) begin
          len_d   = '0;
          phase_d = PH_EXT16;
        end else if (b[6:0] == LenCode64) begin
          len_d   = '0;
          phase_d = PH_EXT64;
        end else begin
          len_d    = {{(LenW-7){1'b0}}, b[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_d = {len_q[LenW-ByteW-1:0], b};
        cnt_d = cnt_inc;
        len_done = (phase_q == PH_EXT16) ? (cnt_inc >= Ext16Bytes)
                                         : (cnt_inc >= Ext64Bytes);
      end
      PH_KEY: begin
        key_d = {key_q[KeyW-ByteW-1:0], b};
        cnt_d = cnt_inc;
        hdr_done = (cnt_inc >= KeyBytes);
      end
      PH_DATA: begin
        rem_d     = (rem_q != '0) ? rem_q - 64'd1 : rem_q;
        last      = (rem_d == '0);
        if (last) begin
          phase_d = PH_FIRST;
        end
        hit       = 1'b1;
        kind      = KIND_DATA;
        data_byte = b;
        inc       = last ? 1'b0 : eod;
      end
      default: begin
        phase_d  = PH_FIRST;
        cnt_d    = '0;
        len_d    = '0;
        key_d    = '0;
        rem_d    = '0;
        fin_d    = 1'b0;
        op_d     = '0;
        masked_d = 1'b0;
      end
    endcase

    // length known: key bytes follow, or the header ends here
    if (len_done) begin
      cnt_d = '0;
      if (masked_d) begin
        phase_d = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      cnt_d = '0;
      rem_d = len_d;
      hit   = 1'b1;
      kind  = KIND_HEADER;
      if (len_d == '0) begin
        phase_d = PH_FIRST;
        last    = 1'b1;
      end else begin
        phase_d = PH_DATA;
        inc     = eod;
      end
    end

    // data ran out inside a header
    if (!hit && eod) begin
      hit  = 1'b1;
      kind = KIND_INCOMPLETE;
      inc  = 1'b1;
    end
  end

  assign take_o      = in_valid_i && (!hit || out_free_i);
  assign res_valid_o = take_o && hit;

  always_comb begin
    res_o.kind           = kind;
    res_o.fin            = fin_d;
    res_o.opcode         = op_d;
    res_o.masked         = masked_d;
    res_o.payload_length = len_d;
    res_o.masking_key    = masked_d ? key_d : '0;
    res_o.data_byte      = data_byte;
    res_o.last_of_frame  = last;
    res_o.incomplete     = inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      cnt_q    <= '0;
      len_q    <= '0;
      key_q    <= '0;
      rem_q    <= '0;
      fin_q    <= 1'b0;
      op_q     <= '0;
      masked_q <= 1'b0;
    end else if (take_o) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      key_q    <= key_d;
      rem_q    <= rem_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
      masked_q <= masked_d;
    end
  end

  // a header with payload leads into the payload phase
  a_hdr_to_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_HEADER && !res_o.last_of_frame
    |=> phase_q == PH_DATA)
    else $error("header with payload did not enter payload phase");

  // payload results come only from the payload phase
  a_data_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_DATA |-> phase_q == PH_DATA)
    else $error("payload result outside payload phase");

  // the end of a frame returns to the first header byte
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_of_frame |=> phase_q == PH_FIRST)
    else $error("frame end did not restart header parsing");

endmodule

@@ rtl/core/wsd_out_stage.sv @@
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  wsd_result_t res_i,
  output logic        free_o,
  output logic        valid_o,
  input  logic        ready_i,
  output wsd_result_t res_o
);

  logic        valid_q, valid_d;
  wsd_result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (wr_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ rtl/core/websocket_frame_deframer.sv @@
// WebSocket (RFC 6455) frame header parser. Frame stream bytes enter one per item on the
// slave stream; tlast on that side marks the last byte currently available. For each frame
// one header result (tuser kind 0) follows its last header byte, carrying FIN, opcode, mask
// bit, the decoded 7/16/64-bit length and the masking key (zero when unmasked); then every
// payload byte leaves raw, still masked, as a kind 1 item, the final one with tlast set. A
// zero-length frame ends with tlast on its header result. If the data runs out inside a
// header, a kind 2 notice with the incomplete flag is sent; the parser keeps its place and
// the next byte continues the same frame. Throughput is one byte per clock, with no gaps,
// while the master side accepts results; the parse state, with its 64-bit remaining-byte
// count, is updated once per accepted byte. An accepted byte passes the input register,
// then the parse logic into the result register, before reaching the master side. Bytes
// that make no result pass through even while a result waits on a stalled master side.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side: frame stream bytes
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // in_byte [7:0]
  input  logic                s_axis_tlast,   // end_of_data
  // master side: parse results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // fin [0], opcode [4:1], masked [5], payload_length [69:6], masking_key [101:70],
  // data_byte [109:102], incomplete [110], zero [111]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,   // last_of_frame
  output logic [1:0]          m_axis_tuser    // kind
);

  wsd_in_t     in_item;
  wsd_in_t     held_item;
  logic        held_valid;
  logic        take;
  logic        out_free;
  logic        res_wr;
  wsd_result_t res;
  wsd_result_t out_res;

  assign in_item.in_byte     = s_axis_tdata;
  assign in_item.end_of_data = s_axis_tlast;

  // input register
  wsd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (take),
    .item_o  (held_item)
  );

  // frame state and per-byte decode
  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (held_valid),
    .in_item_i   (held_item),
    .take_o      (take),
    .out_free_i  (out_free),
    .res_valid_o (res_wr),
    .res_o       (res)
  );

  // result register
  wsd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.incomplete, out_res.data_byte, out_res.masking_key,
                         out_res.payload_length, out_res.masked, out_res.opcode,
                         out_res.fin};
  assign m_axis_tlast = out_res.last_of_frame;
  assign m_axis_tuser = out_res.kind;

endmodule
